### sv/lsua_pkg.sv
// ----------------------------------------------------------------------------
// Level-set upwind advection: shared package
// Field widths, request kinds and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsua_pkg;

  localparam int PHI_W      = 16;
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 6;
  localparam int SIZE_CFG_W = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COURANT_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COURANT_Y   = 2'd3;

  localparam logic [SIZE_CFG_W-1:0] SIZE_RESET = 7'd64;

endpackage

### sv/lsua_if.sv
// ----------------------------------------------------------------------------
// Level-set upwind advection: channel interfaces
// Request channel (cell write, run, cell read) and response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lsua_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [lsua_pkg::KIND_W-1:0]          kind;
  logic [lsua_pkg::IDX_W-1:0]           row;
  logic [lsua_pkg::IDX_W-1:0]           col;
  logic signed [lsua_pkg::PHI_W-1:0]    phi_in;

  modport source (output valid, kind, row, col, phi_in, input ready);
  modport sink   (input valid, kind, row, col, phi_in, output ready);
endinterface

interface lsua_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lsua_pkg::PHI_W-1:0]    phi_out;
  logic                                 run_done;

  modport source (output valid, phi_out, run_done, input ready);
  modport sink   (input valid, phi_out, run_done, output ready);
endinterface

### sv/lsua_grid_mem.sv
// ----------------------------------------------------------------------------
// Level-set upwind advection: grid memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsua_grid_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic [lsua_pkg::PHI_W-1:0]       wdata,
  input  logic                             re,
  input  logic [AW-1:0]                    raddr,
  output logic [lsua_pkg::PHI_W-1:0]       rdata
);

  logic [lsua_pkg::PHI_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/lsua_upwind.sv
// ----------------------------------------------------------------------------
// Level-set upwind advection: upwind update unit
// Multiplies the Courant number by the upwind difference, registers the
// product, then shifts, adds or subtracts and saturates for the write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsua_upwind #(
  parameter int AW = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [AW-1:0]                     in_addr,
  input  logic signed [lsua_pkg::PHI_W-1:0] prev,
  input  logic signed [lsua_pkg::PHI_W-1:0] cur,
  input  logic signed [lsua_pkg::PHI_W-1:0] next,
  input  logic signed [lsua_pkg::PHI_W-1:0] courant,
  output logic                              out_valid,
  output logic [AW-1:0]                     out_addr,
  output logic [lsua_pkg::PHI_W-1:0]        out_phi
);

  localparam int PW = lsua_pkg::PHI_W;

  logic                    sel;
  logic signed [PW:0]      diff;
  logic signed [2*PW:0]    prod;

  logic                    valid_q;
  logic                    sel_q;
  logic [AW-1:0]           addr_q;
  logic signed [PW-1:0]    phi_q;
  logic signed [2*PW:0]    prod_q;

  logic signed [PW+1:0]    quot;
  logic signed [PW+2:0]    sum;

  // A negative Courant number looks downstream, otherwise upstream.
  always_comb begin
    sel  = courant[PW-1];
    diff = sel ? ({next[PW-1], next} - {cur[PW-1], cur})
               : ({prev[PW-1], prev} - {cur[PW-1], cur});
    prod = courant * diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sel_q  <= sel;
    addr_q <= in_addr;
    phi_q  <= cur;
    prod_q <= prod;
  end

  // Dropping the low fifteen bits of a two's complement value is a floor shift.
  always_comb begin
    quot = prod_q[2*PW:PW-1];
    if (sel_q) begin
      sum = {{3{phi_q[PW-1]}}, phi_q} - {quot[PW+1], quot};
    end else begin
      sum = {{3{phi_q[PW-1]}}, phi_q} + {quot[PW+1], quot};
    end
    if (sum > 19'sd32767) begin
      out_phi = 16'h7FFF;
    end else if (sum < -19'sd32768) begin
      out_phi = 16'h8000;
    end else begin
      out_phi = sum[PW-1:0];
    end
  end

  assign out_valid = valid_q;
  assign out_addr  = addr_q;

endmodule

### sv/level_set_upwind_advection_unit.sv
// ----------------------------------------------------------------------------
// Level-set upwind advection unit
// Holds a grid of Q8.8 level-set values and advects its interior with two
// dimensionally split first-order upwind passes.
//
// Requests arrive on req: a cell write, a run, or a cell read. Responses leave
// on rsp: a read returns the cell (zero outside the store), a run returns
// run_done with a zero value; a write and an unused kind give no response.
// Configuration registers are loaded through cfg_write/cfg_index/cfg_data;
// the user must do so only while the block is idle; it does not enforce this.
// A write goes straight to the store from its transfer. A read passes the memory
// read register and then the output register before its response is valid.
// A run streams the interior lines of the grid, rows and then columns, through
// the single memory read port at one cell per cycle and drains at each line end.
// The next request is taken in the cycle after a read or run finishes.
// Reset restores the size and Courant registers; grid contents are undefined
// until written. While rsp is stalled the result sits in the output register
// and requests are still taken; a later read or run waits at its end until
// the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module level_set_upwind_advection_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [lsua_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lsua_pkg::CFG_DATA_W-1:0]       cfg_data,
  lsua_req_if.sink                              req,
  lsua_rsp_if.source                            rsp
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SZW   = $clog2(MAXD + 1);
  localparam int PW    = lsua_pkg::PHI_W;
  localparam int SCW   = lsua_pkg::SIZE_CFG_W;

  localparam logic [AW-1:0] X_START = AW'(2 * MAX_WIDTH + 1);
  localparam logic [AW-1:0] Y_START = AW'(MAX_WIDTH + 2);
  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);
  localparam logic [AW-1:0] COL_STEP = AW'(1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_LINE  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [SCW-1:0]        grid_width;
  logic [SCW-1:0]        grid_height;
  logic signed [PW-1:0]  courant_x;
  logic signed [PW-1:0]  courant_y;

  // Scan state.
  logic                  pass_y;
  logic [SZW-1:0]        eff_w, eff_h;
  logic [SZW-1:0]        eff_w_c, eff_h_c;
  logic [SZW-1:0]        scan_pos, last_pos;
  logic [SZW-1:0]        scan_line, last_line;
  logic [AW-1:0]         scan_addr, line_base;
  logic [AW-1:0]         stride, line_step;

  // Read pipeline and window.
  logic                  rv;
  logic [AW-1:0]         raddr_q;
  logic [SZW-1:0]        rpos_q;
  logic signed [PW-1:0]  win_prev, win_cur;
  logic                  rd_inside;

  // Memory and update unit connections.
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [PW-1:0]         mem_wdata, mem_rdata;
  logic                  wb_valid;
  logic [AW-1:0]         wb_addr;
  logic [PW-1:0]         wb_phi;

  // Request decode.
  logic                  accept;
  logic                  req_inside;
  logic [AW-1:0]         req_addr;
  logic                  run_start, run_empty;
  logic                  scan_issue;
  logic                  pipe_empty;

  // Output register.
  logic                  out_valid;
  logic [PW-1:0]         out_phi;
  logic                  out_run;
  logic                  slot_free, load_out;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= lsua_pkg::SIZE_RESET;
      grid_height <= lsua_pkg::SIZE_RESET;
      courant_x   <= '0;
      courant_y   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lsua_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data[SCW-1:0];
        lsua_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data[SCW-1:0];
        lsua_pkg::REG_COURANT_X:   courant_x   <= cfg_data;
        lsua_pkg::REG_COURANT_Y:   courant_y   <= cfg_data;
      endcase
    end
  end

  // Sizes in use, clamped to the store.
  always_comb begin
    if (grid_width == '0) begin
      eff_w_c = SZW'(1);
    end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
      eff_w_c = SZW'(MAX_WIDTH);
    end else begin
      eff_w_c = SZW'(grid_width);
    end
    if (grid_height == '0) begin
      eff_h_c = SZW'(1);
    end else if (32'(grid_height) > 32'(MAX_HEIGHT)) begin
      eff_h_c = SZW'(MAX_HEIGHT);
    end else begin
      eff_h_c = SZW'(grid_height);
    end
  end

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  assign req.ready  = !rst && (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign req_inside = (32'(req.row) < 32'(MAX_HEIGHT)) && (32'(req.col) < 32'(MAX_WIDTH));
  assign req_addr   = AW'(32'(req.row) * MAX_WIDTH + 32'(req.col));
  assign run_start  = accept && (req.kind == lsua_pkg::KIND_RUN);
  assign run_empty  = (eff_w_c < SZW'(5)) || (eff_h_c < SZW'(5));

  assign stride     = pass_y ? ROW_STEP : COL_STEP;
  assign line_step  = pass_y ? COL_STEP : ROW_STEP;
  assign scan_issue = (state == S_LINE);
  assign pipe_empty = !rv && !wb_valid;

  assign slot_free  = !out_valid || rsp.ready;
  assign load_out   = ((state == S_READ) || (state == S_DONE)) && slot_free;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (req.kind == lsua_pkg::KIND_READ) begin
            state_next = S_READ;
          end else if (req.kind == lsua_pkg::KIND_RUN) begin
            state_next = run_empty ? S_DONE : S_LINE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_READ: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_LINE: begin
        if (scan_pos == last_pos) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (pipe_empty) begin
          if ((scan_line == last_line) && pass_y) begin
            state_next = S_DONE;
          end else begin
            state_next = S_LINE;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pass_y <= 1'b0;
      rv     <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= scan_issue;
      if (run_start) begin
        pass_y <= 1'b0;
      end else if ((state == S_DRAIN) && pipe_empty && (scan_line == last_line)) begin
        pass_y <= 1'b1;
      end
    end
  end

  // Scan counters and addresses.
  always_ff @(posedge clk) begin
    if (run_start) begin
      eff_w     <= eff_w_c;
      eff_h     <= eff_h_c;
      scan_pos  <= SZW'(1);
      last_pos  <= eff_w_c - SZW'(2);
      scan_line <= SZW'(2);
      last_line <= eff_h_c - SZW'(3);
      line_base <= X_START;
      scan_addr <= X_START;
    end else if (scan_issue) begin
      scan_pos  <= scan_pos + SZW'(1);
      scan_addr <= scan_addr + stride;
    end else if ((state == S_DRAIN) && pipe_empty) begin
      scan_pos <= SZW'(1);
      if (scan_line == last_line) begin
        // End of the x pass: the y pass walks columns top to bottom.
        scan_line <= SZW'(2);
        last_line <= eff_w - SZW'(3);
        last_pos  <= eff_h - SZW'(2);
        line_base <= Y_START;
        scan_addr <= Y_START;
      end else begin
        scan_line <= scan_line + SZW'(1);
        line_base <= line_base + line_step;
        scan_addr <= line_base + line_step;
      end
    end
  end

  // Read pipeline: the window holds the two cells before the one arriving.
  always_ff @(posedge clk) begin
    raddr_q <= scan_addr;
    rpos_q  <= scan_pos;
    if (rv) begin
      win_prev <= win_cur;
      win_cur  <= mem_rdata;
    end
    if (accept) begin
      rd_inside <= req_inside;
    end
  end

  // --------------------------------------------------------------------------
  // Memory and update unit
  // --------------------------------------------------------------------------
  always_comb begin
    mem_re    = scan_issue || (accept && (req.kind == lsua_pkg::KIND_READ) && req_inside);
    mem_raddr = scan_issue ? scan_addr : req_addr;
    mem_we    = wb_valid || (accept && (req.kind == lsua_pkg::KIND_WRITE) && req_inside);
    mem_waddr = wb_valid ? wb_addr : req_addr;
    mem_wdata = wb_valid ? wb_phi : req.phi_in;
  end

  lsua_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lsua_upwind #(
    .AW (AW)
  ) u_upwind (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rv && (rpos_q >= SZW'(3))),
    .in_addr   (raddr_q - stride),
    .prev      (win_prev),
    .cur       (win_cur),
    .next      (mem_rdata),
    .courant   (pass_y ? courant_y : courant_x),
    .out_valid (wb_valid),
    .out_addr  (wb_addr),
    .out_phi   (wb_phi)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_run <= (state == S_DONE);
      out_phi <= ((state == S_READ) && rd_inside) ? mem_rdata : '0;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.phi_out  = out_phi;
  assign rsp.run_done = out_run;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_wb_in_scan: assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> (state == S_LINE) || (state == S_DRAIN))
    else $error("write-back outside a scan");

  a_no_same_cell: assert property (@(posedge clk) disable iff (rst)
    (scan_issue && wb_valid) |-> (mem_raddr != mem_waddr))
    else $error("scan read hits the cell being written back");

  a_drain_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DRAIN) && !pipe_empty) |=> (state == S_DRAIN))
    else $error("line drain left with updates in flight");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> pipe_empty)
    else $error("run reported with updates in flight");

endmodule
